// ===== rtl/rrfp_pkg.sv =====
// package for the radar report frame parser: constants, byte codes and shared types
package rrfp_pkg;

    localparam int BODY_BYTES = 256;
    localparam int GATES      = 32;
    localparam int GATE_W     = $clog2(GATES);
    localparam int FULL_BODY  = 3 + GATES * 4;

    localparam logic [7:0] HDR_B0  = 8'hF4;
    localparam logic [7:0] HDR_B1  = 8'hF3;
    localparam logic [7:0] HDR_B2  = 8'hF2;
    localparam logic [7:0] HDR_B3  = 8'hF1;
    localparam logic [7:0] FOOT_B0 = 8'hF8;
    localparam logic [7:0] FOOT_B1 = 8'hF7;
    localparam logic [7:0] FOOT_B2 = 8'hF6;
    localparam logic [7:0] FOOT_B3 = 8'hF5;

    localparam logic KIND_SUMMARY = 1'b0;
    localparam logic KIND_ENERGY  = 1'b1;

    typedef struct packed {
        logic              en;
        logic [GATE_W-1:0] addr;
        logic [31:0]       data;
    } t_ram_wr;

    typedef struct packed {
        logic        done;      // valid frame ended on this transaction
        logic        full;      // body carried all gate energy words
        logic        at_end;    // parser waits for the last footer byte
        logic [7:0]  presence;
        logic [15:0] distance;
    } t_parse_evt;

endpackage

// ===== rtl/rrfp_if.sv =====
// handshake interfaces for the received byte channel and the result item channel
interface rrfp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface rrfp_item_if;
    logic        valid;
    logic        ready;
    logic        item_kind;
    logic [7:0]  presence;
    logic [15:0] distance_cm;
    logic [4:0]  gate_index;
    logic [31:0] gate_energy;
    logic        last;

    modport source (output valid, output item_kind, output presence, output distance_cm,
                    output gate_index, output gate_energy, output last, input ready);
    modport sink (input valid, input item_kind, input presence, input distance_cm,
                  input gate_index, input gate_energy, input last, output ready);
endinterface

// ===== rtl/radar_report_frame_parser.sv =====
// top level: frame parser, gate energy memory and result drain
// Takes one received byte per cycle. Frames are F4 F3 F2 F1, a little-endian
// 16-bit length (1..256 accepted), the body and F8 F7 F6 F5. A good footer
// with a body of at least 3 bytes gives a summary transaction; a body of at
// least 131 bytes adds 32 gate energy transactions, the last one flagged.
// Gate energy words are kept in a 32 x 32 memory with a registered read; the
// next address is only issued once the previous word has left, so each energy
// transaction waits for its read to settle, and the drain also stalls under
// output back-pressure; byte input is held off during that
// drain. The last footer byte is held off only while a previous result still
// waits at the output. No clearing pass is needed.
module radar_report_frame_parser
    import rrfp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    rrfp_byte_if.sink   i_rx,
    rrfp_item_if.source o_item
);

    t_ram_wr    wr;
    t_parse_evt evt;
    logic       take;

    logic [31:0] mem [GATES];
    logic [31:0] r_rd_data;
    logic        r_rd_ok;

    logic              r_drain;
    logic [GATE_W-1:0] r_gate;

    logic        r_ovalid;
    logic        r_kind;
    logic [7:0]  r_presence;
    logic [15:0] r_distance;
    logic [4:0]  r_gate_index;
    logic [31:0] r_energy;
    logic        r_last;

    logic out_free;
    logic advance;
    logic load_sum;

    assign out_free = !r_ovalid || o_item.ready;
    assign i_rx.ready = !r_drain && (out_free || !evt.at_end);
    assign take = i_rx.valid && i_rx.ready;

    rrfp_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_byte  (i_rx.rx_byte),
        .o_wr    (wr),
        .o_evt   (evt)
    );

    // writes only happen while bytes are taken; reads happen every cycle but are used only during the drain
    always_ff @(posedge i_clk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
        r_rd_data <= mem[r_gate];
    end

    assign load_sum = evt.done;
    assign advance  = r_drain && r_rd_ok && out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drain  <= 1'b0;
            r_gate   <= '0;
            r_rd_ok  <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            // r_rd_ok is set once r_rd_data holds the word read from the current r_gate
            r_rd_ok <= r_drain && !advance;
            if (load_sum) begin
                r_ovalid <= 1'b1;
                r_drain  <= evt.full;
                r_gate   <= '0;
            end else if (advance) begin
                r_ovalid <= 1'b1;
                r_gate   <= r_gate + 1'b1;
                if (r_gate == GATE_W'(GATES - 1)) begin
                    r_drain <= 1'b0;
                end
            end else if (o_item.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_sum) begin
            r_kind       <= KIND_SUMMARY;
            r_presence   <= evt.presence;
            r_distance   <= evt.distance;
            r_gate_index <= '0;
            r_energy     <= '0;
            r_last       <= !evt.full;
        end else if (advance) begin
            r_kind       <= KIND_ENERGY;
            r_presence   <= '0;
            r_distance   <= '0;
            r_gate_index <= 5'(r_gate);
            r_energy     <= r_rd_data;
            r_last       <= r_gate == GATE_W'(GATES - 1);
        end
    end

    assign o_item.valid       = r_ovalid;
    assign o_item.item_kind   = r_kind;
    assign o_item.presence    = r_presence;
    assign o_item.distance_cm = r_distance;
    assign o_item.gate_index  = r_gate_index;
    assign o_item.gate_energy = r_energy;
    assign o_item.last        = r_last;

endmodule

// ===== rtl/rrfp_parser.sv =====
// byte-level frame parser: header, length, body capture and footer check
module rrfp_parser
    import rrfp_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_take,
    input  logic [7:0]       i_byte,
    output t_ram_wr          o_wr,
    output t_parse_evt       o_evt
);

    localparam logic [3:0] PH_IDLE  = 4'd0;
    localparam logic [3:0] PH_HDR2  = 4'd1;
    localparam logic [3:0] PH_HDR3  = 4'd2;
    localparam logic [3:0] PH_HDR4  = 4'd3;
    localparam logic [3:0] PH_LEN1  = 4'd4;
    localparam logic [3:0] PH_LEN2  = 4'd5;
    localparam logic [3:0] PH_BODY  = 4'd6;
    localparam logic [3:0] PH_FOOT1 = 4'd7;
    localparam logic [3:0] PH_FOOT2 = 4'd8;
    localparam logic [3:0] PH_FOOT3 = 4'd9;
    localparam logic [3:0] PH_FOOT4 = 4'd10;

    logic [3:0]  r_phase, n_phase;
    logic [15:0] r_len, n_len;
    logic [15:0] r_pos, n_pos;
    logic [7:0]  r_presence, n_presence;
    logic [15:0] r_distance, n_distance;
    logic [23:0] r_acc, n_acc;

    logic [15:0] len_full;
    logic [16:0] pos_inc;
    logic [7:0]  rel;

    assign len_full = {i_byte, r_len[7:0]};
    assign pos_inc  = {1'b0, r_pos} + 17'd1;
    assign rel      = r_pos[7:0] - 8'd3;

    always_comb begin
        n_phase        = r_phase;
        n_len          = r_len;
        n_pos          = r_pos;
        n_presence     = r_presence;
        n_distance     = r_distance;
        n_acc          = r_acc;
        o_wr.en        = 1'b0;
        o_wr.addr      = rel[GATE_W+1:2];
        o_wr.data      = {i_byte, r_acc};
        o_evt.done     = 1'b0;
        o_evt.full     = r_len >= 16'(FULL_BODY);
        o_evt.at_end   = r_phase == PH_FOOT4;
        o_evt.presence = r_presence;
        o_evt.distance = r_distance;
        if (i_take) begin
            case (r_phase)
                PH_IDLE:  n_phase = (i_byte == HDR_B0) ? PH_HDR2 : PH_IDLE;
                PH_HDR2:  n_phase = (i_byte == HDR_B1) ? PH_HDR3 : PH_IDLE;
                PH_HDR3:  n_phase = (i_byte == HDR_B2) ? PH_HDR4 : PH_IDLE;
                PH_HDR4:  n_phase = (i_byte == HDR_B3) ? PH_LEN1 : PH_IDLE;
                PH_LEN1: begin
                    n_len   = {8'd0, i_byte};
                    n_phase = PH_LEN2;
                end
                PH_LEN2: begin
                    n_len = len_full;
                    n_pos = '0;
                    if (len_full == '0 || {1'b0, len_full} > 17'(BODY_BYTES)) begin
                        n_phase = PH_IDLE;
                    end else begin
                        n_phase = PH_BODY;
                    end
                end
                PH_BODY: begin
                    if (r_pos == 16'd0) begin
                        n_presence = i_byte;
                    end else if (r_pos == 16'd1) begin
                        n_distance[7:0] = i_byte;
                    end else if (r_pos == 16'd2) begin
                        n_distance[15:8] = i_byte;
                    end else if (r_pos < 16'(FULL_BODY)) begin
                        // three bytes gathered, the fourth completes the word
                        case (rel[1:0])
                            2'd0:    n_acc[7:0]   = i_byte;
                            2'd1:    n_acc[15:8]  = i_byte;
                            2'd2:    n_acc[23:16] = i_byte;
                            default: o_wr.en      = 1'b1;
                        endcase
                    end
                    n_pos = pos_inc[15:0];
                    if (pos_inc >= {1'b0, r_len}) begin
                        n_phase = PH_FOOT1;
                    end
                end
                PH_FOOT1: n_phase = (i_byte == FOOT_B0) ? PH_FOOT2 : PH_IDLE;
                PH_FOOT2: n_phase = (i_byte == FOOT_B1) ? PH_FOOT3 : PH_IDLE;
                PH_FOOT3: n_phase = (i_byte == FOOT_B2) ? PH_FOOT4 : PH_IDLE;
                PH_FOOT4: begin
                    n_phase    = PH_IDLE;
                    o_evt.done = (i_byte == FOOT_B3) && (r_len >= 16'd3);
                end
                default:  n_phase = PH_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_len      <= '0;
            r_pos      <= '0;
            r_presence <= '0;
            r_distance <= '0;
        end else begin
            r_phase    <= n_phase;
            r_len      <= n_len;
            r_pos      <= n_pos;
            r_presence <= n_presence;
            r_distance <= n_distance;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
    end

endmodule
